>>> hw/rtl/tsc_pkg.sv
// Shared types and constants for the text statistics counter.
// No dependencies; used by tsc_classify, tsc_counters and the top level.
package tsc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int OUT_WIDTH       = 16;

  // Slots of the counter bank; the newline slot is reported as lines.
  localparam int CNT_BYTES     = 0;
  localparam int CNT_NONSPACE  = 1;
  localparam int CNT_WORDS     = 2;
  localparam int CNT_NEWLINES  = 3;
  localparam int CNT_VOWELS    = 4;
  localparam int CNT_CONSONANT = 5;
  localparam int CNT_DIGITS    = 6;
  localparam int CNT_SPACES    = 7;
  localparam int CNT_OTHER     = 8;
  localparam int NUM_CNT       = 9;

  localparam logic [7:0] CHR_A     = 8'h61;
  localparam logic [7:0] CHR_E     = 8'h65;
  localparam logic [7:0] CHR_I     = 8'h69;
  localparam logic [7:0] CHR_O     = 8'h6F;
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_UC_A  = 8'h41;
  localparam logic [7:0] CHR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef struct packed {
    logic ws;
    logic newline;
    logic vowel;
    logic consonant;
    logic digit;
    logic other;
  } tsc_class_t;

endpackage

>>> hw/rtl/tsc_classify.sv
// Byte classifier: sorts one byte into C-locale classes.
// Depends on tsc_pkg.
module tsc_classify import tsc_pkg::*; (
  input  logic [7:0] byte_i,
  output tsc_class_t class_o
);

  logic       ws, letter, is_vowel, digit;
  logic [7:0] lower;

  always_comb begin
    ws       = (byte_i == CHR_SPACE) || (byte_i >= CHR_TAB && byte_i <= CHR_CR);
    letter   = (byte_i >= CHR_UC_A && byte_i <= CHR_UC_Z) ||
               (byte_i >= CHR_A && byte_i <= CHR_LC_Z);
    lower    = byte_i | CASE_BIT;
    is_vowel = (lower == CHR_A) || (lower == CHR_E) || (lower == CHR_I) ||
               (lower == CHR_O) || (lower == CHR_U);
    digit    = (byte_i >= CHR_ZERO) && (byte_i <= CHR_NINE);

    class_o.ws        = ws;
    class_o.newline   = (byte_i == CHR_NL);
    class_o.vowel     = letter && is_vowel;
    class_o.consonant = letter && !is_vowel;
    class_o.digit     = digit;
    class_o.other     = !ws && !letter && !digit;
  end

endmodule

>>> hw/rtl/tsc_counters.sv
// Saturating counter bank and word tracking; presents the totals that
// include the current byte. Depends on tsc_pkg.
module tsc_counters import tsc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 last_i,
  input  tsc_class_t           class_i,
  output logic [OUT_WIDTH-1:0] totals_o [NUM_CNT]
);

  localparam int EXT_W = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

  logic [COUNT_WIDTH-1:0] cnt_q [NUM_CNT];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_CNT];
  logic [NUM_CNT-1:0]     inc;
  logic                   inside_word_q;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v != '1) ? v + COUNT_WIDTH'(1) : v;
  endfunction

  always_comb begin
    inc                = '0;
    inc[CNT_BYTES]     = 1'b1;
    inc[CNT_NONSPACE]  = !class_i.ws;
    inc[CNT_WORDS]     = !class_i.ws && !inside_word_q;
    inc[CNT_NEWLINES]  = class_i.newline;
    inc[CNT_VOWELS]    = class_i.vowel;
    inc[CNT_CONSONANT] = class_i.consonant;
    inc[CNT_DIGITS]    = class_i.digit;
    inc[CNT_SPACES]    = class_i.ws;
    inc[CNT_OTHER]     = class_i.other;
  end

  always_comb begin
    logic [COUNT_WIDTH-1:0] val;
    logic [EXT_W-1:0]       ext;
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_d[i] = inc[i] ? sat_inc(cnt_q[i]) : cnt_q[i];
      // lines is one more than the newline count
      val = (i == CNT_NEWLINES) ? sat_inc(cnt_d[i]) : cnt_d[i];
      ext = EXT_W'(val);
      totals_o[i] = ext[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
      inside_word_q <= 1'b0;
    end else if (advance_i) begin
      if (last_i) begin
        for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
        inside_word_q <= 1'b0;
      end else begin
        for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= cnt_d[i];
        inside_word_q <= !class_i.ws;
      end
    end
  end

endmodule

>>> hw/rtl/text_statistics_counter.sv
// Top level of the text statistics counter.
// Depends on tsc_pkg, tsc_classify and tsc_counters.

// The block takes a text one byte per beat on the input channel, with
// end_of_text_i set on the final byte, and on that byte delivers one result
// beat with nine totals: bytes, non-whitespace bytes, words, lines (one plus
// the newline count), vowels, consonants, digits, whitespace bytes and other
// bytes, all counted as in the C locale (bytes 0x80 and up are other). Bytes
// without end_of_text_i give no result. Every count saturates at
// 2^COUNT_WIDTH - 1 and each result field carries its low 16 bits. After the
// final byte all counts clear, so the next byte starts a new text. A byte
// is captured in an input register, then classified and counted, and the
// totals of a final byte land in a result register. The block takes one
// byte every cycle while input is not stalled; input stalls only when a
// finished result is still waiting in the result register and the next
// final byte needs it.
module text_statistics_counter import tsc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_WIDTH-1:0] total_chars_o,
  output logic [OUT_WIDTH-1:0] nonspace_chars_o,
  output logic [OUT_WIDTH-1:0] words_o,
  output logic [OUT_WIDTH-1:0] lines_o,
  output logic [OUT_WIDTH-1:0] vowels_o,
  output logic [OUT_WIDTH-1:0] consonants_o,
  output logic [OUT_WIDTH-1:0] digits_o,
  output logic [OUT_WIDTH-1:0] spaces_o,
  output logic [OUT_WIDTH-1:0] punctuation_o
);

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_advance;
  logic       in_fire;

  // Result register.
  logic                 out_valid_q;
  logic [OUT_WIDTH-1:0] res_q [NUM_CNT];

  tsc_class_t           byte_class;
  logic [OUT_WIDTH-1:0] totals [NUM_CNT];

  // Advance the held byte unless it is a final byte and the result
  // register still holds a beat nobody has taken.
  assign s1_advance = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Payload holds no reset; capture only on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= end_of_text_i;
    end
  end

  tsc_classify u_classify (
    .byte_i  (s1_byte_q),
    .class_o (byte_class)
  );

  tsc_counters #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_advance),
    .last_i    (s1_last_q),
    .class_i   (byte_class),
    .totals_o  (totals)
  );

  // Load a result on a final byte; drop it once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_last_q) begin
      for (int i = 0; i < NUM_CNT; i++) res_q[i] <= totals[i];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign total_chars_o    = res_q[CNT_BYTES];
  assign nonspace_chars_o = res_q[CNT_NONSPACE];
  assign words_o          = res_q[CNT_WORDS];
  assign lines_o          = res_q[CNT_NEWLINES];
  assign vowels_o         = res_q[CNT_VOWELS];
  assign consonants_o     = res_q[CNT_CONSONANT];
  assign digits_o         = res_q[CNT_DIGITS];
  assign spaces_o         = res_q[CNT_SPACES];
  assign punctuation_o    = res_q[CNT_OTHER];

`ifndef SYNTHESIS
  // A final byte must wait while an untaken result occupies the register.
  a_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("final byte advanced over a pending result");

  // A new result appears only right after a final byte advanced.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q && s1_advance))
    else $error("result loaded without a final byte");

  // Lines is at least one when the count is not truncated.
  a_lines_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (COUNT_WIDTH > OUT_WIDTH) || (lines_o != '0))
    else $error("line count of zero");

  // Nonspace and space bytes never exceed the total, nor words the nonspace.
  a_totals_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (COUNT_WIDTH > OUT_WIDTH) ||
      ((nonspace_chars_o <= total_chars_o) && (spaces_o <= total_chars_o) &&
       (words_o <= nonspace_chars_o)))
    else $error("class counts exceed byte total");
`endif

endmodule

>>> verif/tsc_tally_pkg.sv
// Scoreboard for the text statistics counter bench: predicts the nine totals
// of each text from the accepted bytes and checks every result beat.
// Depends on tsc_pkg for the counter slots, character codes and widths.
`timescale 1ns / 100ps
package tsc_tally_pkg;
  import tsc_pkg::*;

  typedef logic [NUM_CNT-1:0][OUT_WIDTH-1:0] totals_t;

  class text_tally;
    bit [32:0]   counts [NUM_CNT];
    bit [32:0]   cap;
    bit          in_word;
    string       field_name [NUM_CNT];
    totals_t     pending_totals [$];
    int unsigned totals_checked;
    int unsigned mismatches;

    function new(int unsigned width);
      cap = (33'd1 << width) - 33'd1;
      field_name[CNT_BYTES]     = "total_chars";
      field_name[CNT_NONSPACE]  = "nonspace_chars";
      field_name[CNT_WORDS]     = "words";
      field_name[CNT_NEWLINES]  = "lines";
      field_name[CNT_VOWELS]    = "vowels";
      field_name[CNT_CONSONANT] = "consonants";
      field_name[CNT_DIGITS]    = "digits";
      field_name[CNT_SPACES]    = "spaces";
      field_name[CNT_OTHER]     = "punctuation";
      clear();
    endfunction

    function void clear();
      foreach (counts[s]) counts[s] = '0;
      in_word = 1'b0;
    endfunction

    function void bump(int slot);
      if (counts[slot] < cap) counts[slot] = counts[slot] + 33'd1;
    endfunction

    function int waiting();
      return pending_totals.size();
    endfunction

    // Note one accepted input beat; a final byte queues the expected totals.
    function void take_byte(logic [7:0] b, logic last);
      logic [7:0] folded;
      bit [32:0]  lines_full;
      totals_t    t;
      folded = b | CASE_BIT;
      bump(CNT_BYTES);
      if (b == CHR_NL) bump(CNT_NEWLINES);
      if (b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR)) begin
        in_word = 1'b0;
        bump(CNT_SPACES);
      end else begin
        if (!in_word) bump(CNT_WORDS);
        in_word = 1'b1;
        bump(CNT_NONSPACE);
        if ((b >= CHR_UC_A && b <= CHR_UC_Z) || (b >= CHR_A && b <= CHR_LC_Z)) begin
          if (folded == CHR_A || folded == CHR_E || folded == CHR_I ||
              folded == CHR_O || folded == CHR_U) bump(CNT_VOWELS);
          else bump(CNT_CONSONANT);
        end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
          bump(CNT_DIGITS);
        end else begin
          bump(CNT_OTHER);
        end
      end
      if (last) begin
        for (int s = 0; s < NUM_CNT; s++) t[s] = counts[s][OUT_WIDTH-1:0];
        // Lines is one more than the newlines, saturating like the rest.
        lines_full = (counts[CNT_NEWLINES] < cap) ? counts[CNT_NEWLINES] + 33'd1 : cap;
        t[CNT_NEWLINES] = lines_full[OUT_WIDTH-1:0];
        pending_totals.push_back(t);
        clear();
      end
    endfunction

    // Check one result beat against the oldest expected totals.
    function void check_totals(totals_t got);
      totals_t want;
      if (pending_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with no finished text pending: total_chars %0d",
                   got[CNT_BYTES]);
        return;
      end
      want = pending_totals.pop_front();
      for (int s = 0; s < NUM_CNT; s++) begin
        if (want[s] !== got[s]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("text %0d: %s expected %0d, got %0d",
                     totals_checked, field_name[s], want[s], got[s]);
        end
      end
      totals_checked++;
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
// Top of the text statistics counter bench: drives texts byte by byte with
// random idling on both channels and checks every totals beat.
// Depends on tsc_pkg, tsc_tally_pkg and the text_statistics_counter RTL.
`timescale 1ns / 100ps
module tb_top;
  import tsc_pkg::*;
  import tsc_tally_pkg::*;

  localparam int CNT_W        = COUNT_WIDTH_DEF;
  localparam int HALF_PERIOD  = 4;
  localparam int LATENCY      = 2;
  localparam int RANDOM_BYTES = 1250;

  // Directed texts as {end_of_text, byte}: one-byte texts, the zero byte,
  // bytes at and above 0x80, the letter and digit class boundaries, and whitespace.
  localparam logic [8:0] PROBE [25] = '{
    {1'b1, CHR_A},                                   // lone vowel
    {1'b1, CHR_SPACE},                               // lone blank: no word
    {1'b1, CHR_NL},                                  // lone newline: two lines
    {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b1, 8'h7F},
    {1'b0, CHR_TAB}, {1'b0, CHR_UC_A}, {1'b0, 8'h45}, {1'b0, CHR_UC_Z},
    {1'b0, 8'h0B}, {1'b0, CHR_ZERO}, {1'b0, CHR_NINE}, {1'b0, CHR_CR},
    {1'b0, CHR_U}, {1'b0, CHR_LC_Z}, {1'b0, 8'h40}, {1'b0, 8'h5B},
    {1'b0, 8'h60}, {1'b0, 8'h7B}, {1'b0, CHR_NL}, {1'b0, 8'h0C},
    {1'b0, 8'h2F}, {1'b1, 8'h3A}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           text_byte_i   = '0;
  logic                 end_of_text_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [OUT_WIDTH-1:0] total_chars_o;
  logic [OUT_WIDTH-1:0] nonspace_chars_o;
  logic [OUT_WIDTH-1:0] words_o;
  logic [OUT_WIDTH-1:0] lines_o;
  logic [OUT_WIDTH-1:0] vowels_o;
  logic [OUT_WIDTH-1:0] consonants_o;
  logic [OUT_WIDTH-1:0] digits_o;
  logic [OUT_WIDTH-1:0] spaces_o;
  logic [OUT_WIDTH-1:0] punctuation_o;

  // Longest idle stretch each side may draw per beat; phases change these.
  int unsigned in_gap_max  = 12;
  int unsigned out_gap_max = 12;
  int unsigned bytes_sent  = 0;
  int unsigned texts_sent  = 0;

  text_tally tally;

  text_statistics_counter #(.COUNT_WIDTH(CNT_W)) uut (.*);

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Send one byte: idle a random number of cycles, then hold valid and the
  // payload until the beat is taken. Valid stays high across back-to-back
  // beats, so it is only lowered when a gap is drawn.
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tally.take_byte(b, last);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  // Draw a text-like byte: mostly letters with blanks between them so that
  // words and lines form, plus digits, punctuation, high bytes and zero.
  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return (($urandom_range(1, 0) != 0) ? CHR_UC_A : CHR_A) +
                       8'($urandom_range(25, 0));
    if (r < 60) return CHR_ZERO + 8'($urandom_range(9, 0));
    if (r < 72) return CHR_SPACE;
    if (r < 76) return CHR_NL;
    if (r < 80) return CHR_TAB + 8'($urandom_range(4, 0));
    if (r < 90) return 8'($urandom_range(47, 33));
    if (r < 98) return 8'($urandom_range(255, 128));
    return 8'h00;
  endfunction

  // Result side: stall a random number of cycles before each beat, then
  // hold ready until a beat arrives and check it.
  initial begin
    int unsigned stall;
    totals_t     got;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(out_gap_max, 0);
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got[CNT_BYTES]     = total_chars_o;
      got[CNT_NONSPACE]  = nonspace_chars_o;
      got[CNT_WORDS]     = words_o;
      got[CNT_NEWLINES]  = lines_o;
      got[CNT_VOWELS]    = vowels_o;
      got[CNT_CONSONANT] = consonants_o;
      got[CNT_DIGITS]    = digits_o;
      got[CNT_SPACES]    = spaces_o;
      got[CNT_OTHER]     = punctuation_o;
      tally.check_totals(got);
    end
  end

  initial begin
    int unsigned len;
    int unsigned rand_start;
    bit          noisy;
    tally = new(CNT_W);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed texts, with full idling on both sides.
    foreach (PROBE[k]) send_byte(PROBE[k][7:0], PROBE[k][8]);

    // Random texts: mostly text-like, some pure noise. Advance through four
    // idling mixes: both sides idling, none, slow receiver, slow sender.
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      case ((bytes_sent - rand_start) * 4 / RANDOM_BYTES)
        0:       begin in_gap_max = 12; out_gap_max = 12; end
        1:       begin in_gap_max = 0;  out_gap_max = 0;  end
        2:       begin in_gap_max = 2;  out_gap_max = 12; end
        default: begin in_gap_max = 12; out_gap_max = 1;  end
      endcase
      len   = ($urandom_range(19, 0) == 0) ? $urandom_range(300, 41)
                                           : $urandom_range(24, 1);
      noisy = ($urandom_range(4, 0) == 0);
      for (int unsigned k = 0; k < len; k++)
        send_byte(noisy ? 8'($urandom) : pick_text_byte(), k == len - 1);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain: hold until every text has reported, then idle a little longer
    // to catch any stray result beat.
    while (tally.waiting() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);

    $display("Drove %0d texts, %0d bytes: class-boundary probes, then random texts",
             texts_sent, bytes_sent);
    $display("under four idling mixes. Checked %0d totals beats; %0d field mismatches.",
             tally.totals_checked, tally.mismatches);
    if (tally.mismatches == 0 && tally.waiting() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: the slowest legal run stays under 0.4 ms, so allow about five times.
  initial begin
    #(2_000_000);
    $display("Timed out with %0d texts still pending.", tally.waiting());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
